FILE: hw/rtl/pgci_pkg.sv
// Shared constants and codes for the periodic grid cell index block.
package pgci_pkg;

	// Default geometry of the fixed-point datapath
	localparam int AXIS_BITS_DEF = 10;
	localparam int FRAC_BITS_DEF = 16;

	// Field widths
	localparam int COORD_W = 32;   // positions and cell coordinates
	localparam int SHAPE_W = 11;   // shape registers
	localparam int INV_W   = 32;   // inverse spacing registers
	localparam int PROD_W  = 64;   // exact position * inverse spacing
	localparam int IDX_W   = 30;   // linear cell index
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;

	// Remainder bits retired per pipeline stage
	localparam int REM_STEP = 4;

	// Reset values
	localparam logic [SHAPE_W-1:0] SHAPE_RST = SHAPE_W'(1);
	localparam logic [INV_W-1:0]   INV_RST   = INV_W'(65536);

	// Command codes
	localparam logic CMD_BIN  = 1'b0;  // bin a Q16.16 position
	localparam logic CMD_CELL = 1'b1;  // check and linearize cell coordinates

	// Register map
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SHAPE_X = 3'd0,
		REG_SHAPE_Y = 3'd1,
		REG_SHAPE_Z = 3'd2,
		REG_INV_X   = 3'd3,
		REG_INV_Y   = 3'd4,
		REG_INV_Z   = 3'd5
	} cfg_reg_t;

endpackage

FILE: hw/rtl/periodic_grid_cell_index.sv
// Top level: pipelined periodic 3D grid binning and cell linearization.
//
//  channel | signals                                      | direction
//  --------+----------------------------------------------+----------
//  in      | in_valid, in_ready, command, pos_*, cell_*   | to block
//  out     | out_valid, out_ready, cell_index, inside_box,| from block
//          | coord_oob                                    |
//  cfg     | cfg_valid, cfg_ready, cfg_index, cfg_data    | to block
//
// One transaction per cycle sustained while the output is not stalled. The
// floored modulo by the shape is a chain of NSTEP restoring remainder
// stages, NSTEP = ceil((64 - 2*FRAC_BITS) / 4), four quotient bits per stage.
// Every stage has its own valid bit and load enable, so bubbles collapse and
// a stalled output only backs up the stages that are full.
// Reset clears the valid bits and sets the registers to shape 1 and inverse
// spacing 1.0. Config writes are taken every cycle (cfg_ready is tied high).
module periodic_grid_cell_index #(
	parameter int AXIS_BITS = pgci_pkg::AXIS_BITS_DEF,
	parameter int FRAC_BITS = pgci_pkg::FRAC_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// input transactions
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic                                command,
	input  logic signed [pgci_pkg::COORD_W-1:0] pos_x,
	input  logic signed [pgci_pkg::COORD_W-1:0] pos_y,
	input  logic signed [pgci_pkg::COORD_W-1:0] pos_z,
	input  logic signed [pgci_pkg::COORD_W-1:0] cell_x,
	input  logic signed [pgci_pkg::COORD_W-1:0] cell_y,
	input  logic signed [pgci_pkg::COORD_W-1:0] cell_z,
	// result transactions
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [pgci_pkg::IDX_W-1:0]          cell_index,
	output logic                                inside_box,
	output logic                                coord_oob,
	// register writes
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [pgci_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [pgci_pkg::CFG_DATA_W-1:0]     cfg_data
);

	localparam int AW     = AXIS_BITS;
	localparam int IW     = pgci_pkg::IDX_W;
	localparam int PW     = pgci_pkg::PROD_W;
	localparam int SW     = pgci_pkg::SHAPE_W;
	localparam int STEP   = pgci_pkg::REM_STEP;
	localparam int QW     = PW - 2 * FRAC_BITS;          // integer part of product
	localparam int NSTEP  = (QW + STEP - 1) / STEP;      // remainder stages
	localparam int MW     = NSTEP * STEP;                // padded magnitude
	localparam int CW     = (QW > AW + 1) ? QW : AW + 1; // inside compare width
	localparam int EW     = (SW > AW + 1) ? SW : AW + 1; // shape clamp width
	localparam int SYZW   = (2 * (AW + 1) > IW) ? 2 * (AW + 1) : IW;
	localparam int TYW    = (2 * AW + 1 > IW) ? 2 * AW + 1 : IW;
	localparam int TXW    = AW + IW;

	// Stage 1: products and mode 1 bounds check
	typedef struct packed {
		logic [2:0][PW-1:0] prod;
		logic [2:0][AW-1:0] cell_lo;
		logic               cmd;
		logic               bad;
	} mul_t;

	// Stage 2 and remainder stages
	typedef struct packed {
		logic [2:0][MW-1:0] mag;
		logic [2:0][AW-1:0] rem;
		logic [2:0]         neg;
		logic               cmd;
		logic               bad;
		logic               in_box;
	} rem_t;

	// Stage 3: reduced cell coordinates
	typedef struct packed {
		logic [2:0][AW-1:0] c;
		logic               cmd;
		logic               bad;
		logic               in_box;
	} crd_t;

	// Stage 4: linearization terms
	typedef struct packed {
		logic [IW-1:0] tz;
		logic [IW-1:0] ty;
		logic [IW-1:0] tx;
		logic          cmd;
		logic          bad;
		logic          in_box;
	} lin_t;

	// Clamp a raw shape register into 1..2^AXIS_BITS
	function automatic logic [AW:0] eff_shape(input logic [SW-1:0] raw);
		logic [EW-1:0] r;
		logic [EW-1:0] lim;
		logic [EW-1:0] s;
		r   = EW'(raw);
		lim = EW'(1) << AW;
		if (raw == '0)
			s = EW'(1);
		else if (r > lim)
			s = lim;
		else
			s = r;
		return s[AW:0];
	endfunction

	// Configuration registers
	logic [2:0][SW-1:0]              shape_q;
	logic [2:0][pgci_pkg::INV_W-1:0] inv_q;
	logic [IW-1:0]                   syz_q;

	logic [2:0][AW:0] shp;
	logic [SYZW-1:0]  syz_full;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int a = 0; a < 3; a++) begin
				shape_q[a] <= pgci_pkg::SHAPE_RST;
				inv_q[a]   <= pgci_pkg::INV_RST;
			end
		end else if (cfg_valid) begin
			case (pgci_pkg::cfg_reg_t'(cfg_index))
				pgci_pkg::REG_SHAPE_X: shape_q[0] <= cfg_data[SW-1:0];
				pgci_pkg::REG_SHAPE_Y: shape_q[1] <= cfg_data[SW-1:0];
				pgci_pkg::REG_SHAPE_Z: shape_q[2] <= cfg_data[SW-1:0];
				pgci_pkg::REG_INV_X:   inv_q[0]   <= cfg_data;
				pgci_pkg::REG_INV_Y:   inv_q[1]   <= cfg_data;
				pgci_pkg::REG_INV_Z:   inv_q[2]   <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		for (int a = 0; a < 3; a++)
			shp[a] = eff_shape(shape_q[a]);
	end

	// ny*nz for the x term, only needed modulo 2^IW
	assign syz_full = SYZW'(shp[1]) * SYZW'(shp[2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			syz_q <= IW'(1);
		else
			syz_q <= syz_full[IW-1:0];
	end

	// Stage valids and load enables
	logic             vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;
	logic [NSTEP-1:0] vld_sr;
	logic             en_s1, en_s2, en_s3, en_s4, en_s5;
	logic [NSTEP-1:0] en_sr;

	assign en_s5 = !vld_s5 || out_ready;
	assign en_s4 = !vld_s4 || en_s5;
	assign en_s3 = !vld_s3 || en_s4;
	assign en_sr[NSTEP-1] = !vld_sr[NSTEP-1] || en_s3;
	for (genvar j = 0; j < NSTEP - 1; j++) begin : g_en
		assign en_sr[j] = !vld_sr[j] || en_sr[j+1];
	end
	assign en_s2 = !vld_s2 || en_sr[0];
	assign en_s1 = !vld_s1 || en_s2;
	assign in_ready = en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_sr <= '0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else begin
			if (en_s1) vld_s1 <= in_valid;
			if (en_s2) vld_s2 <= vld_s1;
			if (en_sr[0]) vld_sr[0] <= vld_s2;
			for (int j = 1; j < NSTEP; j++)
				if (en_sr[j]) vld_sr[j] <= vld_sr[j-1];
			if (en_s3) vld_s3 <= vld_sr[NSTEP-1];
			if (en_s4) vld_s4 <= vld_s3;
			if (en_s5) vld_s5 <= vld_s4;
		end
	end

	// Stage 1: signed position times unsigned inverse spacing
	logic signed [pgci_pkg::COORD_W-1:0] pos_a  [3];
	logic signed [pgci_pkg::COORD_W-1:0] cell_a [3];
	mul_t nxt_s1, st_s1;

	assign pos_a[0]  = pos_x;
	assign pos_a[1]  = pos_y;
	assign pos_a[2]  = pos_z;
	assign cell_a[0] = cell_x;
	assign cell_a[1] = cell_y;
	assign cell_a[2] = cell_z;

	always_comb begin
		logic signed [PW-1:0] pe;
		logic signed [PW-1:0] ie;
		logic                 any_bad;
		any_bad = 1'b0;
		for (int a = 0; a < 3; a++) begin
			pe = PW'(pos_a[a]);
			ie = PW'({1'b0, inv_q[a]});
			nxt_s1.prod[a] = pe * ie;
			nxt_s1.cell_lo[a] = cell_a[a][AW-1:0];
			if (cell_a[a][pgci_pkg::COORD_W-1] ||
			    $unsigned(cell_a[a]) >= pgci_pkg::COORD_W'(shp[a]))
				any_bad = 1'b1;
		end
		nxt_s1.cmd = command;
		nxt_s1.bad = (command == pgci_pkg::CMD_CELL) && any_bad;
	end

	always_ff @(posedge clk) begin
		if (en_s1) st_s1 <= nxt_s1;
	end

	// Stage 2: floor, sign and magnitude, inside test
	rem_t nxt_s2, st_s2;

	always_comb begin
		logic [QW-1:0] q;
		logic [QW-1:0] nq;
		logic [CW-1:0] qc;
		logic [CW-1:0] sc;
		logic          ok;
		logic          ok_all;
		nxt_s2 = '0;
		ok_all = 1'b1;
		for (int a = 0; a < 3; a++) begin
			q  = st_s1.prod[a][PW-1:2*FRAC_BITS];
			nq = ~q + QW'(1);
			qc = CW'(q);
			sc = CW'(shp[a]);
			// product in [0, shape * 2^(2F)]
			ok = !st_s1.prod[a][PW-1] &&
			     (qc < sc || (qc == sc && st_s1.prod[a][2*FRAC_BITS-1:0] == '0));
			if (st_s1.cmd == pgci_pkg::CMD_BIN) begin
				nxt_s2.neg[a] = st_s1.prod[a][PW-1];
				nxt_s2.mag[a] = st_s1.prod[a][PW-1] ? MW'(nq) : MW'(q);
			end else begin
				// a valid cell coordinate is its own remainder
				nxt_s2.neg[a] = 1'b0;
				nxt_s2.mag[a] = MW'(st_s1.cell_lo[a]);
			end
			ok_all = ok_all && ok;
		end
		nxt_s2.cmd    = st_s1.cmd;
		nxt_s2.bad    = st_s1.bad;
		nxt_s2.in_box = (st_s1.cmd == pgci_pkg::CMD_BIN) && ok_all;
	end

	always_ff @(posedge clk) begin
		if (en_s2) st_s2 <= nxt_s2;
	end

	// Remainder stages: restoring modulo, STEP bits of magnitude each
	rem_t st_sr [NSTEP];

	for (genvar j = 0; j < NSTEP; j++) begin : g_rem
		rem_t src;
		rem_t nxt;

		if (j == 0) begin : g_first
			assign src = st_s2;
		end else begin : g_next
			assign src = st_sr[j-1];
		end

		always_comb begin
			logic [AW:0]   t;
			logic [AW-1:0] r;
			nxt = src;
			for (int a = 0; a < 3; a++) begin
				r = src.rem[a];
				for (int b = 0; b < STEP; b++) begin
					t = {r, src.mag[a][MW-1-j*STEP-b]};
					if (t >= shp[a])
						t = t - shp[a];
					r = t[AW-1:0];
				end
				nxt.rem[a] = r;
			end
		end

		always_ff @(posedge clk) begin
			if (en_sr[j]) st_sr[j] <= nxt;
		end
	end

	// Stage 3: floored modulo for negative values
	crd_t nxt_s3, st_s3;

	always_comb begin
		logic [AW:0] d;
		for (int a = 0; a < 3; a++) begin
			d = shp[a] - (AW+1)'(st_sr[NSTEP-1].rem[a]);
			if (st_sr[NSTEP-1].neg[a] && st_sr[NSTEP-1].rem[a] != '0)
				nxt_s3.c[a] = d[AW-1:0];
			else
				nxt_s3.c[a] = st_sr[NSTEP-1].rem[a];
		end
		nxt_s3.cmd    = st_sr[NSTEP-1].cmd;
		nxt_s3.bad    = st_sr[NSTEP-1].bad;
		nxt_s3.in_box = st_sr[NSTEP-1].in_box;
	end

	always_ff @(posedge clk) begin
		if (en_s3) st_s3 <= nxt_s3;
	end

	// Stage 4: y*nz and x*ny*nz
	lin_t        nxt_s4, st_s4;
	logic [TYW-1:0] ty_full;
	logic [TXW-1:0] tx_full;

	assign ty_full = TYW'(st_s3.c[1]) * TYW'(shp[2]);
	assign tx_full = TXW'(st_s3.c[0]) * TXW'(syz_q);

	always_comb begin
		nxt_s4.tz     = IW'(st_s3.c[2]);
		nxt_s4.ty     = ty_full[IW-1:0];
		nxt_s4.tx     = tx_full[IW-1:0];
		nxt_s4.cmd    = st_s3.cmd;
		nxt_s4.bad    = st_s3.bad;
		nxt_s4.in_box = st_s3.in_box;
	end

	always_ff @(posedge clk) begin
		if (en_s4) st_s4 <= nxt_s4;
	end

	// Stage 5: sum and output register
	logic [IW-1:0] idx_s5;
	logic          inside_s5;
	logic          oor_s5;
	logic [IW-1:0] idx_sum;

	assign idx_sum = st_s4.tz + st_s4.ty + st_s4.tx;

	always_ff @(posedge clk) begin
		if (en_s5) begin
			idx_s5    <= st_s4.bad ? '0 : idx_sum;
			inside_s5 <= st_s4.in_box;
			oor_s5    <= st_s4.bad && (st_s4.cmd == pgci_pkg::CMD_CELL);
		end
	end

	assign out_valid  = vld_s5;
	assign cell_index = idx_s5;
	assign inside_box = inside_s5;
	assign coord_oob  = oor_s5;

endmodule

FILE: hw/rtl/pgci_checker.sv
// Port-level checker for the periodic grid cell index block, with its bind.
module pgci_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       in_valid,
	input logic                       in_ready,
	input logic                       out_valid,
	input logic                       out_ready,
	input logic [pgci_pkg::IDX_W-1:0] cell_index,
	input logic                       inside_box,
	input logic                       coord_oob
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(cell_index) &&
		$stable(inside_box) && $stable(coord_oob))
		else $error("result changed while stalled");

	// out of range results carry index 0
	a_oor_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && coord_oob |-> cell_index == '0)
		else $error("out of range result with nonzero index");

	// the two flags belong to different modes
	a_flags_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(inside_box && coord_oob))
		else $error("inside_box and coord_oob both set");

	// input only backs up when the pipe is full behind a stalled output
	a_in_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid && !out_ready)
		else $error("input stalled without output back-pressure");

endmodule

bind periodic_grid_cell_index pgci_checker u_pgci_checker (.*);

FILE: sim/tb_top.sv
// Testbench for periodic_grid_cell_index: random and directed lookups checked against a predictor.
`timescale 1ns / 1ps

module tb_top;

	localparam int AXIS = pgci_pkg::AXIS_BITS_DEF;
	localparam int FRAC = pgci_pkg::FRAC_BITS_DEF;
	localparam int COORD_W = pgci_pkg::COORD_W;
	localparam int IDX_W = pgci_pkg::IDX_W;
	localparam int SHAPE_W = pgci_pkg::SHAPE_W;
	localparam int INV_W = pgci_pkg::INV_W;
	localparam int CFG_IDX_W = pgci_pkg::CFG_IDX_W;
	localparam int CFG_DATA_W = pgci_pkg::CFG_DATA_W;
	localparam int LATENCY =
		(pgci_pkg::PROD_W - 2 * FRAC + pgci_pkg::REM_STEP - 1) / pgci_pkg::REM_STEP + 5;
	localparam int DRAIN_CYCLES = 3 * LATENCY;
	localparam int RANDOM_PHASES = 8;
	localparam int ITEMS_PER_PHASE = 216;
	localparam int LONG_HOLD = 150;
	localparam int FIRST_HOLD_AT = 400;
	localparam int SECOND_HOLD_AT = 1200;
	localparam longint POS_MAX = 64'sd2147483647;
	localparam longint POS_MIN = -64'sd2147483648;

	// Indexes outside the register map; writes to them must change nothing
	localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_LO = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_HI = 3'd7;

	typedef struct packed {
		logic                      command;
		logic signed [COORD_W-1:0] pos_x;
		logic signed [COORD_W-1:0] pos_y;
		logic signed [COORD_W-1:0] pos_z;
		logic signed [COORD_W-1:0] cell_x;
		logic signed [COORD_W-1:0] cell_y;
		logic signed [COORD_W-1:0] cell_z;
	} grid_req_t;

	typedef struct packed {
		logic [IDX_W-1:0] cell_index;
		logic             inside_box;
		logic             coord_oob;
	} cell_result_t;

	// DUT signals
	logic                      clk = 1'b0;
	logic                      arst_n = 1'b0;
	logic                      in_valid = 1'b0;
	logic                      in_ready;
	logic                      command = pgci_pkg::CMD_BIN;
	logic signed [COORD_W-1:0] pos_x = '0;
	logic signed [COORD_W-1:0] pos_y = '0;
	logic signed [COORD_W-1:0] pos_z = '0;
	logic signed [COORD_W-1:0] cell_x = '0;
	logic signed [COORD_W-1:0] cell_y = '0;
	logic signed [COORD_W-1:0] cell_z = '0;
	logic                      out_valid;
	logic                      out_ready = 1'b0;
	logic [IDX_W-1:0]          cell_index;
	logic                      inside_box;
	logic                      coord_oob;
	logic                      cfg_valid = 1'b0;
	logic                      cfg_ready;
	logic [CFG_IDX_W-1:0]      cfg_index = '0;
	logic [CFG_DATA_W-1:0]     cfg_data = '0;

	// Predictor copy of the register file
	logic [SHAPE_W-1:0] shape_q [3] =
		'{pgci_pkg::SHAPE_RST, pgci_pkg::SHAPE_RST, pgci_pkg::SHAPE_RST};
	logic [INV_W-1:0]   inv_q [3] =
		'{pgci_pkg::INV_RST, pgci_pkg::INV_RST, pgci_pkg::INV_RST};

	grid_req_t    point_queue [$];
	cell_result_t expected_cells [$];

	int mismatches = 0;
	int results_seen = 0;
	int bins_sent = 0;
	int cells_sent = 0;
	int inside_seen = 0;
	int oob_seen = 0;
	int geometries = 1;

	// Sender and receiver pacing
	int burst_left = 1;
	int gap_left = 0;
	int hold_left = 0;
	int holds_done = 0;
	int stall_pct = 0;
	logic [5:0] rx_slot = '0;

	periodic_grid_cell_index #(
		.AXIS_BITS(AXIS),
		.FRAC_BITS(FRAC)
	) u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.command     (command),
		.pos_x       (pos_x),
		.pos_y       (pos_y),
		.pos_z       (pos_z),
		.cell_x      (cell_x),
		.cell_y      (cell_y),
		.cell_z      (cell_z),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.cell_index  (cell_index),
		.inside_box  (inside_box),
		.coord_oob   (coord_oob),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	// Shape as the datapath sees it: 0 acts as 1, above 2^AXIS clamps
	function automatic longint eff_shape(int axis);
		longint s;
		s = longint'(shape_q[axis]);
		if (s == 0)
			s = 1;
		if (s > (longint'(1) << AXIS))
			s = longint'(1) << AXIS;
		return s;
	endfunction

	// Expected result for one lookup under the current registers
	function automatic cell_result_t locate_cell(grid_req_t r);
		logic [COORD_W-1:0] pv [3];
		logic [COORD_W-1:0] cv [3];
		longint s [3];
		longint c [3];
		longint prod;
		longint q;
		longint rem;
		logic [63:0] lin;
		logic in_box;
		logic bad;
		int i;
		cell_result_t res;
		pv = '{r.pos_x, r.pos_y, r.pos_z};
		cv = '{r.cell_x, r.cell_y, r.cell_z};
		in_box = 1'b1;
		bad = 1'b0;
		for (i = 0; i < 3; i++) begin
			s[i] = eff_shape(i);
			if (r.command == pgci_pkg::CMD_BIN) begin
				// exact Q32.32 product, floored, then floored modulo
				prod = longint'($signed(pv[i])) * longint'({32'd0, inv_q[i]});
				q = prod >>> (2 * FRAC);
				rem = q % s[i];
				if (rem < 0)
					rem += s[i];
				c[i] = rem;
				if (prod < 0 || prod > (s[i] << (2 * FRAC)))
					in_box = 1'b0;
			end else begin
				c[i] = longint'($signed(cv[i]));
				if (c[i] < 0 || c[i] >= s[i])
					bad = 1'b1;
			end
		end
		lin = c[2] + c[1] * s[2] + c[0] * s[1] * s[2];
		if (r.command == pgci_pkg::CMD_CELL && bad)
			lin = '0;
		res.cell_index = lin[IDX_W-1:0];
		res.inside_box = (r.command == pgci_pkg::CMD_BIN) ? in_box : 1'b0;
		res.coord_oob = (r.command == pgci_pkg::CMD_CELL) ? bad : 1'b0;
		return res;
	endfunction

	task automatic report_mismatch(input string msg);
		$display("MISMATCH @%0t: %s", $realtime, msg);
		mismatches++;
	endtask

	// Position that lands inside, on the edge of, or far from the box
	function automatic logic [31:0] random_pos(int axis);
		longint s;
		longint inv;
		longint target;
		longint p;
		s = eff_shape(axis);
		inv = longint'({32'd0, inv_q[axis]});
		case ($urandom_range(0, 9))
		0, 1, 2: return $urandom();
		3: return $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
		4: target = (s << (2 * FRAC)) + longint'($urandom_range(0, 2)) - 1;
		5: target = longint'($urandom_range(0, int'(s))) << (2 * FRAC);
		6: target = -((longint'($urandom_range(0, 3 * int'(s))) << (2 * FRAC))
			+ longint'($urandom()));
		default: target = (longint'($urandom_range(0, int'(s) - 1)) << (2 * FRAC))
			+ longint'($urandom());
		endcase
		if (inv == 0)
			return $urandom();
		p = target / inv;
		if (p > POS_MAX)
			p = POS_MAX;
		if (p < POS_MIN)
			p = POS_MIN;
		return p[31:0];
	endfunction

	// Cell coordinate, mostly in range, sometimes on or past the bounds
	function automatic logic [31:0] random_cell(int axis);
		int s;
		s = int'(eff_shape(axis));
		case ($urandom_range(0, 19))
		0: return $urandom();
		1: return 32'hFFFF_FFFF;
		2: return s;
		3, 4: return s - 1;
		default: return $urandom_range(0, s - 1);
		endcase
	endfunction

	function automatic logic [SHAPE_W-1:0] pick_shape();
		case ($urandom_range(0, 9))
		0: return '0;
		1: return 11'd1;
		2: return 11'd1024;
		3: return SHAPE_W'($urandom_range(1025, 2047));
		4, 5: return SHAPE_W'($urandom_range(2, 1023));
		default: return SHAPE_W'($urandom_range(1, 16));
		endcase
	endfunction

	function automatic logic [INV_W-1:0] pick_inv();
		case ($urandom_range(0, 9))
		0: return '0;
		1: return 32'hFFFF_FFFF;
		2: return 32'd1;
		3: return $urandom();
		default: return $urandom_range(32'h0000_1000, 32'h0010_0000);
		endcase
	endfunction

	// One register write transaction; the predictor copy follows on acceptance
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
		pgci_pkg::REG_SHAPE_X: shape_q[0] = data[SHAPE_W-1:0];
		pgci_pkg::REG_SHAPE_Y: shape_q[1] = data[SHAPE_W-1:0];
		pgci_pkg::REG_SHAPE_Z: shape_q[2] = data[SHAPE_W-1:0];
		pgci_pkg::REG_INV_X: inv_q[0] = data;
		pgci_pkg::REG_INV_Y: inv_q[1] = data;
		pgci_pkg::REG_INV_Z: inv_q[2] = data;
		default: ;  // unmapped index, ignored
		endcase
	endtask

	// Shape writes sometimes carry junk above the 11 register bits
	task automatic set_geometry(input logic [SHAPE_W-1:0] sx, input logic [SHAPE_W-1:0] sy,
			input logic [SHAPE_W-1:0] sz, input logic [INV_W-1:0] ix,
			input logic [INV_W-1:0] iy, input logic [INV_W-1:0] iz);
		logic [31:0] junk;
		junk = $urandom_range(0, 1) ? $urandom() : '0;
		write_reg(pgci_pkg::REG_SHAPE_X, {junk[31:SHAPE_W], sx});
		junk = $urandom_range(0, 1) ? $urandom() : '0;
		write_reg(pgci_pkg::REG_SHAPE_Y, {junk[31:SHAPE_W], sy});
		junk = $urandom_range(0, 1) ? $urandom() : '0;
		write_reg(pgci_pkg::REG_SHAPE_Z, {junk[31:SHAPE_W], sz});
		write_reg(pgci_pkg::REG_INV_X, ix);
		write_reg(pgci_pkg::REG_INV_Y, iy);
		write_reg(pgci_pkg::REG_INV_Z, iz);
		geometries++;
	endtask

	task automatic queue_bin(input logic [31:0] x, input logic [31:0] y, input logic [31:0] z);
		grid_req_t r;
		r.command = pgci_pkg::CMD_BIN;
		r.pos_x = x;
		r.pos_y = y;
		r.pos_z = z;
		r.cell_x = $urandom();
		r.cell_y = $urandom();
		r.cell_z = $urandom();
		point_queue.push_back(r);
	endtask

	task automatic queue_cell(input logic [31:0] x, input logic [31:0] y, input logic [31:0] z);
		grid_req_t r;
		r.command = pgci_pkg::CMD_CELL;
		r.pos_x = $urandom();
		r.pos_y = $urandom();
		r.pos_z = $urandom();
		r.cell_x = x;
		r.cell_y = y;
		r.cell_z = z;
		point_queue.push_back(r);
	endtask

	task automatic queue_random();
		grid_req_t r;
		r.command = $urandom_range(0, 1) ? pgci_pkg::CMD_CELL : pgci_pkg::CMD_BIN;
		r.pos_x = random_pos(0);
		r.pos_y = random_pos(1);
		r.pos_z = random_pos(2);
		r.cell_x = random_cell(0);
		r.cell_y = random_cell(1);
		r.cell_z = random_cell(2);
		point_queue.push_back(r);
	endtask

	// Sender paused until every transaction is back, then the pipeline settles
	task automatic wait_drained();
		@(negedge clk);
		while (point_queue.size() != 0 || in_valid || expected_cells.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Input driver: bursts of random length with random gaps
	always @(posedge clk or negedge arst_n) begin : drive_points
		grid_req_t nxt;
		if (!arst_n) begin
			in_valid <= 1'b0;
			command <= pgci_pkg::CMD_BIN;
			pos_x <= '0;
			pos_y <= '0;
			pos_z <= '0;
			cell_x <= '0;
			cell_y <= '0;
			cell_z <= '0;
			burst_left <= 1;
			gap_left <= 0;
		end else if (!in_valid || in_ready) begin
			if (gap_left != 0) begin
				in_valid <= 1'b0;
				gap_left <= gap_left - 1;
			end else if (point_queue.size() != 0) begin
				nxt = point_queue.pop_front();
				in_valid <= 1'b1;
				command <= nxt.command;
				pos_x <= nxt.pos_x;
				pos_y <= nxt.pos_y;
				pos_z <= nxt.pos_z;
				cell_x <= nxt.cell_x;
				cell_y <= nxt.cell_y;
				cell_z <= nxt.cell_z;
				if (burst_left <= 1) begin
					burst_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
						: $urandom_range(1, 24);
					gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
				end else begin
					burst_left <= burst_left - 1;
				end
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Receiver: stall rate changes each time the 6-bit slot counter wraps, plus two long hold-offs
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			hold_left <= 0;
			holds_done <= 0;
			stall_pct <= 0;
			rx_slot <= '0;
		end else if (hold_left != 0) begin
			out_ready <= 1'b0;
			hold_left <= hold_left - 1;
		end else if ((holds_done == 0 && results_seen >= FIRST_HOLD_AT) ||
				(holds_done == 1 && results_seen >= SECOND_HOLD_AT)) begin
			out_ready <= 1'b0;
			hold_left <= LONG_HOLD;
			holds_done <= holds_done + 1;
		end else begin
			rx_slot <= rx_slot + 1'b1;
			if (rx_slot == '0) begin
				case ($urandom_range(0, 4))
				0, 1: stall_pct <= 0;
				2: stall_pct <= 20;
				3: stall_pct <= 50;
				default: stall_pct <= 85;
				endcase
			end
			out_ready <= ($urandom_range(0, 99) >= stall_pct);
		end
	end

	// Monitor: check result transactions, then record accepted inputs
	always @(posedge clk) begin : check_results
		cell_result_t want;
		grid_req_t seen;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				results_seen <= results_seen + 1;
				if (expected_cells.size() == 0) begin
					report_mismatch($sformatf("result %0d arrived with nothing expected",
						results_seen));
				end else begin
					want = expected_cells.pop_front();
					inside_seen += want.inside_box;
					oob_seen += want.coord_oob;
					if (cell_index !== want.cell_index)
						report_mismatch($sformatf("result %0d cell_index %0d, expected %0d",
							results_seen, cell_index, want.cell_index));
					if (inside_box !== want.inside_box)
						report_mismatch($sformatf("result %0d inside_box %b, expected %b",
							results_seen, inside_box, want.inside_box));
					if (coord_oob !== want.coord_oob)
						report_mismatch($sformatf("result %0d coord_oob %b, expected %b",
							results_seen, coord_oob, want.coord_oob));
				end
			end
			if (in_valid && in_ready) begin
				seen = '{command: command, pos_x: pos_x, pos_y: pos_y, pos_z: pos_z,
					cell_x: cell_x, cell_y: cell_y, cell_z: cell_z};
				expected_cells.push_back(locate_cell(seen));
				if (command == pgci_pkg::CMD_BIN)
					bins_sent++;
				else
					cells_sent++;
			end
		end
	end

	// Stimulus sequence
	initial begin : run_stimulus
		int k;
		int n;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// registers at reset: one cell, unit spacing
		@(negedge clk);
		queue_bin(32'h0000_8000, 32'h0001_0000, 32'h0000_0000);
		queue_cell(0, 0, 0);
		queue_cell(0, 1, 0);
		wait_drained();

		// small box, mixed spacings; unmapped writes must not disturb it
		set_geometry(11'd3, 11'd5, 11'd7, 32'h0001_0000, 32'h0002_8000, 32'h0000_C000);
		write_reg(REG_UNMAPPED_LO, $urandom());
		write_reg(REG_UNMAPPED_HI, $urandom());
		@(negedge clk);
		queue_bin(0, 0, 0);
		queue_bin(32'h0001_8000, 32'h0001_0000, 32'h0002_0000);
		queue_bin(32'h0003_0000, 32'h0002_0000, 32'h0009_5555);  // x exactly on the far face
		queue_bin(32'h0003_0001, 0, 0);                         // one step past it
		queue_bin(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF); // tiny negatives wrap to last cell
		queue_bin(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
		queue_bin(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
		queue_cell(0, 0, 0);
		queue_cell(2, 4, 6);
		queue_cell(3, 0, 0);
		queue_cell(0, 5, 0);
		queue_cell(0, 0, 7);
		queue_cell(32'hFFFF_FFFF, 0, 0);
		queue_cell(32'h8000_0000, 32'h7FFF_FFFF, 0);
		wait_drained();

		// zero shape, shape past the limit, full shape; zero and extreme spacings
		set_geometry(11'd0, 11'd2047, 11'd1024, 32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0001);
		@(negedge clk);
		queue_bin(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
		queue_bin(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
		queue_bin(32'h1234_5678, 32'h0000_0001, 32'hFFFF_FFFF);
		queue_cell(0, 1023, 1023);  // largest index
		queue_cell(1, 0, 0);
		queue_cell(0, 1024, 0);
		queue_cell(0, 0, 1024);

		// random geometries, each phase drained before the next write
		for (k = 0; k < RANDOM_PHASES; k++) begin
			wait_drained();
			set_geometry(pick_shape(), pick_shape(), pick_shape(),
				pick_inv(), pick_inv(), pick_inv());
			@(negedge clk);
			for (n = 0; n < ITEMS_PER_PHASE; n++)
				queue_random();
		end
		wait_drained();

		$display("Checked %0d results: %0d position bins, %0d cell lookups, %0d geometries.",
			results_seen, bins_sent, cells_sent, geometries);
		$display("Points inside the box: %0d, cell lookups out of range: %0d.",
			inside_seen, oob_seen);
		if (mismatches == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

	// Watchdog
	initial begin
		#2_400_000;
		$display("Timeout with %0d results still expected.", expected_cells.size());
		$display("== FAIL ==");
		$finish;
	end

endmodule

FILE: periodic_grid_cell_index.f
hw/rtl/pgci_pkg.sv
hw/rtl/periodic_grid_cell_index.sv
hw/rtl/pgci_checker.sv
sim/tb_top.sv
